@@ rtl/core/amas_pkg.sv @@
// Shared types, widths and codes of the autorange moving average sensor block.
package amas_pkg;

  localparam int SENSORS     = 4;
  localparam int READ_W      = 10;
  localparam int RAW_W       = 11;
  localparam int LEVEL_W     = 8;
  localparam int CMD_W       = 2;
  localparam int FRONT_LEFT  = 0;
  localparam int FRONT_RIGHT = 3;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Divider widths: the scaled offset is at most 2046 * 255, the span at most 2046,
  // and every quotient this block asks for is known to fit in eight bits.
  localparam int DIV_NUM_W = 19;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_QUO_W = 8;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CALIB  = 2'd2;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  localparam logic [LEVEL_W-1:0]      THRESHOLD_RESET  = 8'd50;
  localparam logic signed [RAW_W-1:0] LOW_LIMIT_RESET  = 11'sd1023;
  localparam logic signed [RAW_W-1:0] HIGH_LIMIT_RESET = 11'sd0;

  typedef logic [LEVEL_W-1:0]      level_t;
  typedef logic signed [RAW_W-1:0] raw_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CLEAR,
    OP_CALIB,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [SENSORS-1:0][RAW_W-1:0] raw;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_NORM,
    BK_NORM_WAIT,
    BK_MEAN,
    BK_MEAN_WAIT,
    BK_OUT
  } back_state_t;

endpackage

@@ rtl/core/amas_front.sv @@
// Input side: takes a reading set, forms lit minus dark per sensor and decodes the command.
module amas_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [amas_pkg::CMD_W-1:0]   cmd,
  input  logic [amas_pkg::READ_W-1:0]  lit_0,
  input  logic [amas_pkg::READ_W-1:0]  dark_0,
  input  logic [amas_pkg::READ_W-1:0]  lit_1,
  input  logic [amas_pkg::READ_W-1:0]  dark_1,
  input  logic [amas_pkg::READ_W-1:0]  lit_2,
  input  logic [amas_pkg::READ_W-1:0]  dark_2,
  input  logic [amas_pkg::READ_W-1:0]  lit_3,
  input  logic [amas_pkg::READ_W-1:0]  dark_3,
  output logic                         item_valid,
  input  logic                         item_ready,
  output amas_pkg::item_t              item
);

  function automatic logic [amas_pkg::RAW_W-1:0] raw_diff(
    input logic [amas_pkg::READ_W-1:0] lit,
    input logic [amas_pkg::READ_W-1:0] dark
  );
    raw_diff = {1'b0, lit} - {1'b0, dark};
  endfunction

  assign item_valid = in_valid;
  assign in_ready   = item_ready;

  always_comb begin
    case (cmd)
      amas_pkg::CMD_SAMPLE: item.op = amas_pkg::OP_SAMPLE;
      amas_pkg::CMD_CLEAR:  item.op = amas_pkg::OP_CLEAR;
      amas_pkg::CMD_CALIB:  item.op = amas_pkg::OP_CALIB;
      default:              item.op = amas_pkg::OP_NONE;
    endcase
    item.raw[0] = raw_diff(lit_0, dark_0);
    item.raw[1] = raw_diff(lit_1, dark_1);
    item.raw[2] = raw_diff(lit_2, dark_2);
    item.raw[3] = raw_diff(lit_3, dark_3);
  end

endmodule

@@ rtl/core/amas_queue.sv @@
// Two-entry queue that decouples the input side from the processing side.
module amas_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  amas_pkg::item_t             push_item,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output amas_pkg::item_t             pop_item,
  output logic [amas_pkg::QCNT_W-1:0] count
);

  amas_pkg::item_t                    entries [amas_pkg::QUEUE_DEPTH];
  logic [amas_pkg::QPTR_W-1:0]        wr_ptr;
  logic [amas_pkg::QPTR_W-1:0]        rd_ptr;
  logic                               push;
  logic                               pop;

  assign push_ready = count != amas_pkg::QCNT_W'(amas_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == amas_pkg::QPTR_W'(amas_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == amas_pkg::QPTR_W'(amas_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/amas_div.sv @@
// Restoring divider that retires two quotient bits per cycle; the quotient must fit in eight bits.
module amas_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [amas_pkg::DIV_NUM_W-1:0] num,
  input  logic [amas_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [amas_pkg::DIV_QUO_W-1:0] quo
);

  localparam int CMP_W = amas_pkg::DIV_DEN_W + amas_pkg::DIV_QUO_W;
  localparam int STEPS = amas_pkg::DIV_QUO_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [CMP_W-1:0] rem;
  logic [CMP_W-1:0] dsh;
  logic [CMP_W-1:0] rem_mid;
  logic [CMP_W-1:0] rem_end;
  logic [CMP_W-1:0] dsh_mid;
  logic             bit_hi;
  logic             bit_lo;
  logic             active;
  logic [CNT_W-1:0] cnt;
  logic             last;

  // The shifted divisor walks down by one bit position per trial subtraction.
  always_comb begin
    bit_hi  = rem >= dsh;
    rem_mid = bit_hi ? rem - dsh : rem;
    dsh_mid = dsh >> 1;
    bit_lo  = rem_mid >= dsh_mid;
    rem_end = bit_lo ? rem_mid - dsh_mid : rem_mid;
  end

  assign last = cnt == CNT_W'(STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && last;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CMP_W'(num);
      dsh <= CMP_W'({den, {(amas_pkg::DIV_QUO_W - 1){1'b0}}});
      quo <= '0;
    end else if (active) begin
      rem <= rem_end;
      dsh <= dsh >> 2;
      quo <= {quo[amas_pkg::DIV_QUO_W-3:0], bit_hi, bit_lo};
    end
  end

endmodule

@@ rtl/core/amas_back.sv @@
// Processing side: calibration limits, normalization, ring window, mean and result register.
module amas_back #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         item_valid,
  output logic                                         item_ready,
  input  amas_pkg::item_t                              item,
  input  logic [amas_pkg::LEVEL_W-1:0]                 threshold,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [amas_pkg::SENSORS-1:0][amas_pkg::LEVEL_W-1:0] out_level,
  output logic                                         out_wall
);

  localparam int SENSORS = amas_pkg::SENSORS;
  localparam int LEVEL_W = amas_pkg::LEVEL_W;
  localparam int RAW_W   = amas_pkg::RAW_W;
  localparam int DIFF_W  = RAW_W + 1;
  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = LEVEL_W + CNT_W;

  amas_pkg::back_state_t state;
  amas_pkg::back_state_t state_next;

  amas_pkg::op_t                        op;
  logic [SENSORS-1:0][RAW_W-1:0]        raw;
  logic [SENSORS-1:0][RAW_W-1:0]        low_limit;
  logic [SENSORS-1:0][RAW_W-1:0]        high_limit;
  logic [SENSORS-1:0][RAW_W-1:0]        low_wide;
  logic [SENSORS-1:0][RAW_W-1:0]        high_wide;
  logic [SENSORS-1:0][LEVEL_W-1:0]      held_level;
  logic [SENSORS-1:0][SUM_W-1:0]        level_sum;
  logic [SENSORS-1:0][LEVEL_W-1:0]      norm_row;
  logic [SENSORS-1:0][LEVEL_W-1:0]      norm_val;
  logic [SENSORS-1:0][LEVEL_W-1:0]      old_row;
  logic [SENSORS-1:0][LEVEL_W-1:0]      old_val;
  logic [SENSORS-1:0]                   span_zero;
  logic [SENSORS-1:0][DIFF_W-1:0]       offset;
  logic [SENSORS-1:0][DIFF_W-1:0]       span;
  logic [SLOT_W-1:0]                    write_slot;
  logic [SLOT_W-1:0]                    cur_slot;
  logic [CNT_W-1:0]                     filled_count;
  logic                                 window_full;
  logic                                 was_full;

  logic [SENSORS-1:0][LEVEL_W-1:0]      window_mem [WINDOW_DEPTH];
  logic                                 mem_rd_en;
  logic                                 mem_wr_en;

  logic                                 div_start;
  logic [SENSORS-1:0][amas_pkg::DIV_NUM_W-1:0] div_num;
  logic [SENSORS-1:0][amas_pkg::DIV_DEN_W-1:0] div_den;
  logic [SENSORS-1:0]                   div_done;
  logic [SENSORS-1:0][LEVEL_W-1:0]      div_quo;
  logic                                 out_load;

  assign window_full = filled_count == CNT_W'(WINDOW_DEPTH);

  // Limits widened by the current reading, and the divider operands of both passes.
  always_comb begin
    for (int k = 0; k < SENSORS; k++) begin
      low_wide[k]  = ($signed(raw[k]) < $signed(low_limit[k]))  ? raw[k] : low_limit[k];
      high_wide[k] = ($signed(raw[k]) > $signed(high_limit[k])) ? raw[k] : high_limit[k];
      offset[k]    = {raw[k][RAW_W-1], raw[k]} - {low_limit[k][RAW_W-1], low_limit[k]};
      span[k]      = {high_limit[k][RAW_W-1], high_limit[k]}
                   - {low_limit[k][RAW_W-1], low_limit[k]};
      norm_val[k]  = span_zero[k] ? '0 : div_quo[k];
      old_val[k]   = was_full ? old_row[k] : '0;
      if (state == amas_pkg::BK_MEAN) begin
        div_num[k] = amas_pkg::DIV_NUM_W'(level_sum[k]);
        div_den[k] = amas_pkg::DIV_DEN_W'(filled_count);
      end else begin
        // Multiplying by 255 is a shift and a subtract.
        div_num[k] = amas_pkg::DIV_NUM_W'({offset[k], {LEVEL_W{1'b0}}}
                                          - {{LEVEL_W{1'b0}}, offset[k]});
        div_den[k] = amas_pkg::DIV_DEN_W'(span[k]);
      end
    end
  end

  for (genvar g = 0; g < SENSORS; g++) begin : g_lane
    amas_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .done  (div_done[g]),
      .quo   (div_quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amas_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    div_start  = 1'b0;
    mem_rd_en  = 1'b0;
    mem_wr_en  = 1'b0;
    out_load   = 1'b0;
    case (state)
      amas_pkg::BK_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = amas_pkg::BK_EXEC;
        end
      end
      amas_pkg::BK_EXEC: begin
        if (op == amas_pkg::OP_SAMPLE) begin
          mem_rd_en  = 1'b1;
          state_next = amas_pkg::BK_NORM;
        end else begin
          state_next = amas_pkg::BK_OUT;
        end
      end
      amas_pkg::BK_NORM: begin
        div_start  = 1'b1;
        state_next = amas_pkg::BK_NORM_WAIT;
      end
      amas_pkg::BK_NORM_WAIT: begin
        if (div_done[0]) begin
          state_next = amas_pkg::BK_MEAN;
        end
      end
      amas_pkg::BK_MEAN: begin
        mem_wr_en  = 1'b1;
        div_start  = 1'b1;
        state_next = amas_pkg::BK_MEAN_WAIT;
      end
      amas_pkg::BK_MEAN_WAIT: begin
        if (div_done[0]) begin
          state_next = amas_pkg::BK_OUT;
        end
      end
      amas_pkg::BK_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = amas_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = amas_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit    <= {SENSORS{amas_pkg::LOW_LIMIT_RESET}};
      high_limit   <= {SENSORS{amas_pkg::HIGH_LIMIT_RESET}};
      held_level   <= '0;
      level_sum    <= '0;
      write_slot   <= '0;
      filled_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        amas_pkg::BK_IDLE: begin
          if (item_valid) begin
            op  <= item.op;
            raw <= item.raw;
          end
        end
        amas_pkg::BK_EXEC: begin
          case (op)
            amas_pkg::OP_CLEAR: begin
              low_limit  <= {SENSORS{amas_pkg::LOW_LIMIT_RESET}};
              high_limit <= {SENSORS{amas_pkg::HIGH_LIMIT_RESET}};
            end
            amas_pkg::OP_CALIB: begin
              low_limit  <= low_wide;
              high_limit <= high_wide;
            end
            amas_pkg::OP_SAMPLE: begin
              low_limit  <= low_wide;
              high_limit <= high_wide;
              cur_slot   <= write_slot;
              write_slot <= (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                       : write_slot + 1'b1;
              was_full   <= window_full;
              if (!window_full) begin
                filled_count <= filled_count + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        amas_pkg::BK_NORM: begin
          for (int k = 0; k < SENSORS; k++) begin
            span_zero[k] <= span[k] == '0;
          end
        end
        amas_pkg::BK_NORM_WAIT: begin
          // The running sum covers exactly the filled entries, so the replaced
          // entry only leaves it once the window has wrapped.
          if (div_done[0]) begin
            norm_row <= norm_val;
            for (int k = 0; k < SENSORS; k++) begin
              level_sum[k] <= level_sum[k] - SUM_W'(old_val[k]) + SUM_W'(norm_val[k]);
            end
          end
        end
        amas_pkg::BK_MEAN_WAIT: begin
          if (div_done[0]) begin
            held_level <= div_quo;
          end
        end
        amas_pkg::BK_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level <= held_level;
      out_wall  <= (held_level[amas_pkg::FRONT_LEFT] > threshold)
                || (held_level[amas_pkg::FRONT_RIGHT] > threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      old_row <= window_mem[write_slot];
    end
    if (mem_wr_en) begin
      window_mem[cur_slot] <= norm_row;
    end
  end

endmodule

@@ rtl/core/autorange_moving_average_sensors_top.sv @@
// Top level of the autorange moving average sensor block with its register port.
//
// Each transaction carries dark and lit readings of four reflective sensors and a command.
// A sample command widens the per-sensor calibration limits, scales lit minus dark into
// 0..255 against those limits, stores it in a WINDOW_DEPTH-entry ring window and returns the
// truncated mean of the filled entries; clear and calibration commands only touch the limits.
// Every command returns one result with the held levels and the wall flag, which is set when
// sensor 0 or sensor 3 lies above wall_threshold (register 0, byte address 0, reset 50).
// A sample command runs two divisions per sensor (scaling, then mean) in four parallel
// dividers that retire two quotient bits per cycle; any other command skips the divisions.
// A two-entry queue takes new transactions while the processing side works, and a result
// register holds the last result until it is taken.
// The window needs no clearing after reset: only entries already written are ever used.
module autorange_moving_average_sensors_top #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [amas_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [amas_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [amas_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [amas_pkg::CMD_W-1:0]        cmd,
  input  logic [amas_pkg::READ_W-1:0]       lit_0,
  input  logic [amas_pkg::READ_W-1:0]       dark_0,
  input  logic [amas_pkg::READ_W-1:0]       lit_1,
  input  logic [amas_pkg::READ_W-1:0]       dark_1,
  input  logic [amas_pkg::READ_W-1:0]       lit_2,
  input  logic [amas_pkg::READ_W-1:0]       dark_2,
  input  logic [amas_pkg::READ_W-1:0]       lit_3,
  input  logic [amas_pkg::READ_W-1:0]       dark_3,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [amas_pkg::LEVEL_W-1:0]      level_0,
  output logic [amas_pkg::LEVEL_W-1:0]      level_1,
  output logic [amas_pkg::LEVEL_W-1:0]      level_2,
  output logic [amas_pkg::LEVEL_W-1:0]      level_3,
  output logic                              wall_ahead
);

  logic [amas_pkg::LEVEL_W-1:0]                               wall_threshold;
  logic                                                       reg_hit;
  logic                                                       front_valid;
  logic                                                       front_ready;
  amas_pkg::item_t                                            front_item;
  logic                                                       q_valid;
  logic                                                       q_ready;
  amas_pkg::item_t                                            q_item;
  logic [amas_pkg::QCNT_W-1:0]                                q_count;
  logic [amas_pkg::SENSORS-1:0][amas_pkg::LEVEL_W-1:0]        out_level;

  assign pready  = 1'b1;
  assign reg_hit = paddr[amas_pkg::APB_ADDR_W-1] == amas_pkg::REG_THRESHOLD;
  assign prdata  = reg_hit ? amas_pkg::APB_DATA_W'(wall_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_threshold <= amas_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      wall_threshold <= pwdata[amas_pkg::LEVEL_W-1:0];
    end
  end

  amas_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .lit_0      (lit_0),
    .dark_0     (dark_0),
    .lit_1      (lit_1),
    .dark_1     (dark_1),
    .lit_2      (lit_2),
    .dark_2     (dark_2),
    .lit_3      (lit_3),
    .dark_3     (dark_3),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  amas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item),
    .count      (q_count)
  );

  amas_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .threshold  (wall_threshold),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level),
    .out_wall   (wall_ahead)
  );

  assign level_0 = out_level[0];
  assign level_1 = out_level[1];
  assign level_2 = out_level[2];
  assign level_3 = out_level[3];

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= amas_pkg::QCNT_W'(amas_pkg::QUEUE_DEPTH))
    else $error("queue holds more transactions than its depth");

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (q_count != '0))
    else $error("accepted transaction did not land in the queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (q_count == amas_pkg::QCNT_W'(amas_pkg::QUEUE_DEPTH)) |-> !in_ready)
    else $error("input side ready while the queue is full");
`endif

endmodule
